// ===== hw/rtl/teq_pkg.sv =====
// Shared types, constants and helper functions of the timed event queue.
package teq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned TAG_BITS    = 16;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned TAG_PORT_W  = 16;
  localparam int unsigned COUNT_W     = 5;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_e;

  typedef struct packed {
    logic [TIME_W-1:0]   time_val;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    cell_op_e op;
    entry_t   new_entry;
  } cell_ctl_t;

  function automatic logic [TAG_BITS-1:0] tag_in(logic [TAG_PORT_W-1:0] t);
    logic [TAG_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < TAG_BITS; i++) begin
      if (i < TAG_PORT_W) r[i] = t[i];
    end
    return r;
  endfunction

  function automatic logic [TAG_PORT_W-1:0] tag_out(logic [TAG_BITS-1:0] t);
    logic [TAG_PORT_W-1:0] r;
    r = '0;
    for (int i = 0; i < TAG_PORT_W; i++) begin
      if (i < TAG_BITS) r[i] = t[i];
    end
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] count_out(logic [CNT_W-1:0] c);
    logic [COUNT_W-1:0] r;
    r = '0;
    for (int i = 0; i < COUNT_W; i++) begin
      if (i < CNT_W) r[i] = c[i];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/teq_cmd_if.sv =====
// Command channel: valid/ready with the command item payload.
interface teq_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           cmd;
  logic signed [teq_pkg::TIME_W-1:0]    time_value;
  logic [teq_pkg::TAG_PORT_W-1:0]       event_tag;

  modport source (output valid, cmd, time_value, event_tag, input ready);
  modport sink   (input valid, cmd, time_value, event_tag, output ready);
endinterface

// ===== hw/rtl/teq_res_if.sv =====
// Result channel: valid/ready with the result item payload.
interface teq_res_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           status;
  logic signed [teq_pkg::TIME_W-1:0]    out_time;
  logic [teq_pkg::TAG_PORT_W-1:0]       out_tag;
  logic signed [teq_pkg::TIME_W-1:0]    last_time;
  logic [teq_pkg::COUNT_W-1:0]          entry_count;

  modport source (output valid, status, out_time, out_tag, last_time, entry_count,
                  input ready);
  modport sink   (input valid, status, out_time, out_tag, last_time, entry_count,
                  output ready);
endinterface

// ===== hw/rtl/timed_event_queue.sv =====
// Top level of the timed event queue: command decode, cell chain, result register.
//
//   channel   dir   handshake      payload
//   cmd_i     in    valid/ready    cmd, time_value, event_tag
//   res_o     out   valid/ready    status, out_time, out_tag, last_time, entry_count
//   cfg       in    we only        time_offset
//
// One item per cycle while results are taken: every cell of the chain updates
// in the same edge, so an insert or a front removal completes in the accepting
// cycle and the result sits in the output register from the next cycle on.
// Reset empties the queue and clears time_offset; no clearing pass.
// A result not yet taken stalls the command side only if it is not taken in
// the same cycle.
module timed_event_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            time_offset_we_i,
  input  logic [teq_pkg::TIME_W-1:0]      time_offset_i,
  teq_cmd_if.sink                         cmd_i,
  teq_res_if.source                       res_o
);

  localparam int unsigned N = teq_pkg::QUEUE_DEPTH;

  logic [teq_pkg::CNT_W-1:0]   count_q, count_d;
  logic [teq_pkg::TIME_W-1:0]  last_q, last_d;
  logic [teq_pkg::TIME_W-1:0]  offset_q;

  logic                            res_valid_q;
  logic [1:0]                      status_q, status_d;
  logic [teq_pkg::TIME_W-1:0]      out_time_q, out_time_d;
  logic [teq_pkg::TAG_PORT_W-1:0]  out_tag_q, out_tag_d;

  teq_pkg::cell_ctl_t ctl;
  teq_pkg::entry_t    entries [N];
  logic [N-1:0]       keep;
  logic [N-1:0]       occ;

  logic                       accept;
  logic                       full, empty, due, at_end;
  logic signed [teq_pkg::TIME_W:0] limit;

  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign full  = (count_q >= teq_pkg::CNT_W'(N));
  assign empty = (count_q == '0);
  assign limit = $signed({cmd_i.time_value[teq_pkg::TIME_W-1], cmd_i.time_value})
               - $signed({offset_q[teq_pkg::TIME_W-1], offset_q});
  assign due   = $signed({entries[0].time_val[teq_pkg::TIME_W-1], entries[0].time_val})
                 <= limit;
  // New entry lands behind everything held when it is not earlier than the tail.
  assign at_end = empty || ($signed(last_q) <= $signed(cmd_i.time_value));

  always_comb begin
    ctl.op                  = teq_pkg::OP_HOLD;
    ctl.new_entry.time_val  = cmd_i.time_value;
    ctl.new_entry.tag       = teq_pkg::tag_in(cmd_i.event_tag);
    count_d                 = count_q;
    last_d                  = last_q;
    status_d                = teq_pkg::ST_NONE;
    out_time_d              = '0;
    out_tag_d               = '0;
    if (accept) begin
      priority if (cmd_i.cmd == teq_pkg::CMD_INSERT) begin
        if (full) begin
          status_d = teq_pkg::ST_FULL;
        end else begin
          ctl.op   = teq_pkg::OP_INSERT;
          count_d  = count_q + 1'b1;
          status_d = teq_pkg::ST_DONE;
          if (at_end) last_d = cmd_i.time_value;
        end
      end else if ((cmd_i.cmd == teq_pkg::CMD_REMOVE && !empty) ||
                   (cmd_i.cmd == teq_pkg::CMD_POP && !empty && due)) begin
        ctl.op     = teq_pkg::OP_REMOVE;
        count_d    = count_q - 1'b1;
        status_d   = teq_pkg::ST_DONE;
        out_time_d = entries[0].time_val;
        out_tag_d  = teq_pkg::tag_out(entries[0].tag);
        if (count_q == teq_pkg::CNT_W'(1)) last_d = '0;
      end else begin
        status_d = teq_pkg::ST_NONE;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    teq_pkg::entry_t prev_e, next_e;
    logic            prev_k;

    assign occ[i] = (count_q > teq_pkg::CNT_W'(i));

    if (i == 0) begin : g_head
      assign prev_e = ctl.new_entry;
      assign prev_k = 1'b1;
    end else begin : g_body
      assign prev_e = entries[i-1];
      assign prev_k = keep[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = entries[i+1];
    end

    teq_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .occ_i        (occ[i]),
      .prev_keep_i  (prev_k),
      .prev_entry_i (prev_e),
      .next_entry_i (next_e),
      .entry_o      (entries[i]),
      .keep_o       (keep[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      last_q      <= '0;
      offset_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      last_q  <= last_d;
      if (time_offset_we_i) offset_q <= time_offset_i;
      if (accept)            res_valid_q <= 1'b1;
      else if (res_o.ready)  res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      out_time_q <= out_time_d;
      out_tag_q  <= out_tag_d;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.status      = status_q;
  assign res_o.out_time    = out_time_q;
  assign res_o.out_tag     = out_tag_q;
  assign res_o.last_time   = last_q;
  assign res_o.entry_count = teq_pkg::count_out(count_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= teq_pkg::CNT_W'(N))
    else $error("entry count above queue depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i.cmd == teq_pkg::CMD_INSERT && !full |=>
      count_q == $past(count_q) + 1'b1)
    else $error("accepted insert did not add an entry");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && status_q == teq_pkg::ST_FULL |-> count_q == teq_pkg::CNT_W'(N))
    else $error("full status with room left");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> last_q == '0)
    else $error("last time not zero on empty queue");

  a_front_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= teq_pkg::CNT_W'(2) |->
      $signed(entries[0].time_val) <= $signed(entries[1].time_val))
    else $error("front entries out of order");
`endif

endmodule

// ===== hw/rtl/teq_cell.sv =====
// One slot of the sorted shift chain: keeps, takes the new entry, or shifts.
module teq_cell (
  input  logic               clk_i,
  input  teq_pkg::cell_ctl_t ctl_i,
  input  logic               occ_i,
  input  logic               prev_keep_i,
  input  teq_pkg::entry_t    prev_entry_i,
  input  teq_pkg::entry_t    next_entry_i,
  output teq_pkg::entry_t    entry_o,
  output logic               keep_o
);

  teq_pkg::entry_t entry_q, entry_d;

  // Held entry stays put on insert if its time is not later than the new one.
  assign keep_o = occ_i &&
                  ($signed(entry_q.time_val) <= $signed(ctl_i.new_entry.time_val));

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      teq_pkg::OP_HOLD:   entry_d = entry_q;
      teq_pkg::OP_INSERT: begin
        if (keep_o)           entry_d = entry_q;
        else if (prev_keep_i) entry_d = ctl_i.new_entry;
        else                  entry_d = prev_entry_i;
      end
      teq_pkg::OP_REMOVE: entry_d = next_entry_i;
      default:            entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== sim/tb_top.sv =====
// Testbench of timed_event_queue: random and directed commands, scoreboard against a queue model.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic [1:0]                        cmd;
    logic signed [teq_pkg::TIME_W-1:0] tval;
    logic [teq_pkg::TAG_PORT_W-1:0]    tag;
  } cmd_item_t;

  typedef struct {
    logic signed [teq_pkg::TIME_W-1:0] tval;
    logic [teq_pkg::TAG_PORT_W-1:0]    tag;
  } event_entry_t;

  typedef struct {
    logic [1:0]                        status;
    logic signed [teq_pkg::TIME_W-1:0] out_time;
    logic [teq_pkg::TAG_PORT_W-1:0]    out_tag;
    logic signed [teq_pkg::TIME_W-1:0] last_time;
    logic [teq_pkg::COUNT_W-1:0]       entry_count;
  } queue_result_t;

  logic clk;
  logic rst_n;
  logic time_offset_we;
  logic [teq_pkg::TIME_W-1:0] time_offset_d;

  teq_cmd_if cmd_ch();
  teq_res_if res_ch();

  timed_event_queue u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .time_offset_we_i(time_offset_we),
    .time_offset_i   (time_offset_d),
    .cmd_i           (cmd_ch),
    .res_o           (res_ch)
  );

  // Stimulus, model state and scoreboard
  cmd_item_t     cmd_backlog[$];
  queue_result_t due_results[$];
  event_entry_t  held_events[$];
  logic signed [teq_pkg::TIME_W-1:0] model_offset;

  cmd_item_t     next_cmd;
  queue_result_t got_result;
  queue_result_t want_result;
  bit            cmd_taken;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;

  int unsigned errors;
  int unsigned results_checked;
  int unsigned n_queued;
  int unsigned n_insert, n_full, n_pop_taken, n_pop_idle, n_remove, n_unused, peak_fill;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one command to the sorted event model and returns its result.
  function automatic queue_result_t track_command(logic [1:0] cmd,
                                                  logic signed [teq_pkg::TIME_W-1:0] tval,
                                                  logic [teq_pkg::TAG_PORT_W-1:0] tag);
    queue_result_t r;
    event_entry_t  e;
    int unsigned   pos;
    longint        limit;
    r = '{status: teq_pkg::ST_NONE, out_time: '0, out_tag: '0, last_time: '0,
          entry_count: '0};
    case (cmd)
      teq_pkg::CMD_INSERT: begin
        n_insert++;
        if (held_events.size() >= teq_pkg::QUEUE_DEPTH) begin
          r.status = teq_pkg::ST_FULL;
          n_full++;
        end else begin
          // equal times stay in arrival order
          pos = 0;
          while (pos < held_events.size() && held_events[pos].tval <= tval) pos++;
          e.tval = tval;
          e.tag  = tag;
          held_events.insert(pos, e);
          r.status = teq_pkg::ST_DONE;
        end
      end
      teq_pkg::CMD_POP: begin
        // exact 33-bit difference, no wrap
        limit = longint'(tval) - longint'(model_offset);
        if (held_events.size() > 0 && longint'(held_events[0].tval) <= limit) begin
          e = held_events[0];
          held_events.delete(0);
          r.status   = teq_pkg::ST_DONE;
          r.out_time = e.tval;
          r.out_tag  = e.tag;
          n_pop_taken++;
        end else begin
          n_pop_idle++;
        end
      end
      teq_pkg::CMD_REMOVE: begin
        n_remove++;
        if (held_events.size() > 0) begin
          e = held_events[0];
          held_events.delete(0);
          r.status   = teq_pkg::ST_DONE;
          r.out_time = e.tval;
          r.out_tag  = e.tag;
        end
      end
      default: n_unused++;
    endcase
    if (held_events.size() > 0) r.last_time = held_events[$].tval;
    r.entry_count = teq_pkg::COUNT_W'(held_events.size());
    if (held_events.size() > peak_fill) peak_fill = held_events.size();
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("error at %0t, result %0d: %s", $time, results_checked, msg);
  endtask

  task automatic compare_result(input queue_result_t got, input queue_result_t want);
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.out_time !== want.out_time)
      report_mismatch($sformatf("out_time %0d, want %0d", got.out_time, want.out_time));
    if (got.out_tag !== want.out_tag)
      report_mismatch($sformatf("out_tag %0h, want %0h", got.out_tag, want.out_tag));
    if (got.last_time !== want.last_time)
      report_mismatch($sformatf("last_time %0d, want %0d", got.last_time, want.last_time));
    if (got.entry_count !== want.entry_count)
      report_mismatch($sformatf("entry_count %0d, want %0d",
                                got.entry_count, want.entry_count));
  endtask

  // Command driver
  always @(negedge clk) begin
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_taken) begin
      if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_cmd = cmd_backlog[0];
        cmd_backlog.delete(0);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.cmd        <= next_cmd.cmd;
        cmd_ch.time_value <= next_cmd.tval;
        cmd_ch.event_tag  <= next_cmd.tag;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver; a requested hold-off overrides the random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check results first, then predict the command taken at this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_taken = 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got_result.status      = res_ch.status;
        got_result.out_time    = res_ch.out_time;
        got_result.out_tag     = res_ch.out_tag;
        got_result.last_time   = res_ch.last_time;
        got_result.entry_count = res_ch.entry_count;
        if (due_results.size() == 0) begin
          report_mismatch("result with none outstanding");
        end else begin
          want_result = due_results[0];
          due_results.delete(0);
          compare_result(got_result, want_result);
        end
        results_checked++;
      end
      cmd_taken = cmd_ch.valid && cmd_ch.ready;
      if (cmd_taken)
        due_results.push_back(track_command(cmd_ch.cmd, cmd_ch.time_value,
                                            cmd_ch.event_tag));
    end
  end

  function automatic logic signed [teq_pkg::TIME_W-1:0] rand_tick();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return teq_pkg::TIME_W'(int'($urandom_range(80)) - 40);
    if (r < 75) begin
      case ($urandom_range(5))
        0: return 32'sh8000_0000;
        1: return 32'sh8000_0001;
        2: return 32'sh7fff_ffff;
        3: return 32'sh7fff_fffe;
        4: return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  task automatic push_cmd(input logic [1:0] cmd,
                          input logic signed [teq_pkg::TIME_W-1:0] tval,
                          input logic [teq_pkg::TAG_PORT_W-1:0] tag);
    cmd_item_t it;
    it.cmd  = cmd;
    it.tval = tval;
    it.tag  = tag;
    cmd_backlog.push_back(it);
    n_queued++;
  endtask

  task automatic push_random(input int unsigned count);
    int unsigned r;
    logic [1:0]  cmd;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 48) cmd = teq_pkg::CMD_INSERT;
      else if (r < 78) cmd = teq_pkg::CMD_POP;
      else if (r < 96) cmd = teq_pkg::CMD_REMOVE;
      else cmd = CMD_UNUSED;
      push_cmd(cmd, rand_tick(), teq_pkg::TAG_PORT_W'($urandom()));
    end
  endtask

  // Waits until every queued command has come back as a checked result.
  task automatic wait_drained();
    do @(negedge clk);
    while (results_checked < n_queued);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_time_offset(input logic signed [teq_pkg::TIME_W-1:0] v);
    @(negedge clk);
    time_offset_we <= 1'b1;
    time_offset_d  <= v;
    @(negedge clk);
    time_offset_we <= 1'b0;
    model_offset = v;
  endtask

  task automatic run_phase(input logic signed [teq_pkg::TIME_W-1:0] offset,
                           input int unsigned idle,
                           input int unsigned stall, input int unsigned count,
                           input bit hold_off);
    set_time_offset(offset);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    push_random(count);
    if (hold_off) begin
      // receiver stops while the sender keeps offering
      repeat (3) @(posedge clk);
      hold_left = HOLD_OFF_CYCLES;
    end
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    time_offset_we = 1'b0;
    time_offset_d = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = teq_pkg::CMD_INSERT;
    cmd_ch.time_value = '0;
    cmd_ch.event_tag = '0;
    res_ch.ready = 1'b0;
    model_offset = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty queue, extremes, equal times, not-due pop, unused code, full
    set_time_offset('0);
    push_cmd(teq_pkg::CMD_POP, '0, '0);
    push_cmd(teq_pkg::CMD_REMOVE, '0, '0);
    push_cmd(CMD_UNUSED, 32'sh7fff_ffff, 16'hffff);
    push_cmd(teq_pkg::CMD_INSERT, 32'sh7fff_ffff, 16'hffff);
    push_cmd(teq_pkg::CMD_INSERT, 32'sh8000_0000, 16'h0000);
    push_cmd(teq_pkg::CMD_INSERT, '0, 16'h1234);
    push_cmd(teq_pkg::CMD_INSERT, '0, 16'h5678);
    push_cmd(teq_pkg::CMD_INSERT, '1, 16'h8000);
    push_cmd(teq_pkg::CMD_POP, 32'sh8000_0000, '0);
    push_cmd(teq_pkg::CMD_POP, -32'sd2, '0);
    push_cmd(CMD_UNUSED, '0, 16'habcd);
    repeat (12) push_cmd(teq_pkg::CMD_INSERT, rand_tick(),
                         teq_pkg::TAG_PORT_W'($urandom()));
    push_cmd(teq_pkg::CMD_INSERT, 32'sd5, 16'h5555);
    wait_drained();

    run_phase('0, 0, 0, 300, 1'b0);
    run_phase(32'sh7fff_ffff, 77, 0, 250, 1'b0);
    run_phase(32'sh8000_0000, 0, 77, 250, 1'b0);
    run_phase($urandom(), 36, 36, 250, 1'b0);
    run_phase(32'sd7, 0, 0, 250, 1'b1);
    run_phase(-32'sd3, 36, 36, 250, 1'b0);

    repeat (10) @(negedge clk);
    $display("%0d commands: %0d inserts (%0d full), %0d pops taken, %0d pops idle, %0d removes",
             n_insert + n_pop_taken + n_pop_idle + n_remove + n_unused, n_insert, n_full,
             n_pop_taken, n_pop_idle, n_remove);
    $display("%0d unused codes, %0d results checked, peak depth %0d, offsets incl. both extremes",
             n_unused, results_checked, peak_fill);
    if (errors == 0) begin
      $display("timed_event_queue: match");
    end else begin
      $display("timed_event_queue: mismatch");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", due_results.size());
    $display("timed_event_queue: mismatch");
    $finish;
  end

endmodule
